>>> design/tdda_pkg.sv
// Shared constants, types and state encoding for the three-axis DDA step generator.
package tdda_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned AccWidth    = 32;
  localparam int unsigned IdxW        = $clog2(BufferDepth);
  localparam int unsigned HalfDepth   = BufferDepth / 2;
  localparam int unsigned HalfW       = (HalfDepth > 1) ? $clog2(HalfDepth) : 1;
  localparam int unsigned NumAxes     = 3;
  localparam int unsigned AxisW       = $clog2(NumAxes);
  localparam int unsigned EntryW      = 2 * NumAxes;
  localparam int unsigned EntryIdxW   = $clog2(EntryW);
  localparam int unsigned ThrW        = 16;
  localparam int unsigned RateW       = 16;
  localparam int unsigned MagW        = RateW + 1;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(1000);

  typedef enum logic [1:0] {
    StIdle,
    StTickOut,
    StFill
  } state_e;

  // Result of one accumulate-and-compare pass for one axis.
  typedef struct packed {
    logic [AccWidth-1:0] acc;
    logic                step;
  } acc_res_t;

endpackage

>>> design/tdda_acc_unit.sv
// Shared accumulate, saturate and threshold-compare unit used once per axis and entry.
module tdda_acc_unit
  import tdda_pkg::*;
(
  input  logic [AccWidth-1:0] acc_i,
  input  logic [MagW-1:0]     mag_i,
  input  logic [ThrW-1:0]     thr_i,
  output acc_res_t            res_o
);

  localparam logic [AccWidth-1:0] AccMax = '1;

  logic [AccWidth:0]   sum;
  logic [AccWidth+1:0] diff;
  logic                ovf;
  logic                ge;

  assign sum  = {1'b0, acc_i} + (AccWidth + 1)'(mag_i);
  assign diff = {1'b0, sum} - (AccWidth + 2)'(thr_i);
  assign ovf  = sum[AccWidth];
  assign ge   = ~diff[AccWidth+1];

  // A saturated sum is always above any threshold, so it steps from the maximum.
  always_comb begin
    if (ovf) begin
      res_o.acc  = AccMax - AccWidth'(thr_i);
      res_o.step = 1'b1;
    end else if (ge) begin
      res_o.acc  = diff[AccWidth-1:0];
      res_o.step = 1'b1;
    end else begin
      res_o.acc  = sum[AccWidth-1:0];
      res_o.step = 1'b0;
    end
  end

endmodule

>>> design/three_axis_dda_step_generator.sv
// Tick request: the entry is read into a read register at acceptance and then loaded into the
// output register; the input stalls until that load, longer while a stalled result holds it.
// Refill request: one axis of one entry per cycle through the shared accumulate unit for half
// the buffer, with the input stalled until that half is written; ignored if no half is due.
// Reset is asynchronous: threshold 1000, index, accumulators and directions zero, all pattern
// store entries marked invalid so that they read as zero until rewritten.
module three_axis_dda_step_generator
  import tdda_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [ThrW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic signed [RateW-1:0] rate_x_i,
  input  logic signed [RateW-1:0] rate_y_i,
  input  logic signed [RateW-1:0] rate_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    step_x_o,
  output logic                    step_y_o,
  output logic                    step_z_o,
  output logic                    dir_x_o,
  output logic                    dir_y_o,
  output logic                    dir_z_o,
  output logic                    refill_due_o
);

  state_e state_q, state_d;

  logic [ThrW-1:0]     thr_q;
  logic [IdxW-1:0]     play_idx_q, play_idx_d;
  logic                half_due_q;
  logic [AccWidth-1:0] acc_q [NumAxes];
  logic [NumAxes-1:0]  last_dir_q;
  logic [MagW-1:0]     mag_q [NumAxes];
  logic [NumAxes-1:0]  dir_q;
  logic [IdxW-1:0]     base_q;
  logic [HalfW-1:0]    ent_cnt_q;
  logic [AxisW-1:0]    axis_q;
  logic [EntryW-1:0]   entry_q, entry_cur;

  logic [EntryW-1:0]      mem [BufferDepth];
  logic [BufferDepth-1:0] mem_vld_q;
  logic [EntryW-1:0]      rd_data_q;
  logic                   rd_vld_q;
  logic [IdxW-1:0]        wr_addr;

  logic              out_valid_q;
  logic [EntryW-1:0] out_entry_q;
  logic              out_due_q;

  logic [RateW-1:0]   rate_arr [NumAxes];
  logic [MagW-1:0]    mag_in [NumAxes];
  logic [NumAxes-1:0] dir_in;

  logic     in_acc, tick_acc, refill_acc, out_free, out_load, fill_last_axis, fill_done;
  logic     step_bit;
  acc_res_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign tick_acc    = in_acc & ~action_i;
  assign refill_acc  = in_acc & action_i & half_due_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_load    = (state_q == StTickOut) & out_free;

  assign fill_last_axis = (axis_q == AxisW'(NumAxes - 1));
  assign fill_done      = fill_last_axis & (ent_cnt_q == HalfW'(HalfDepth - 1));

  assign rate_arr[0] = rate_x_i;
  assign rate_arr[1] = rate_y_i;
  assign rate_arr[2] = rate_z_i;

  // Magnitude keeps the extra bit so that the most negative rate stays exact.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      if (rate_arr[a][RateW-1]) begin
        mag_in[a] = MagW'(1 << RateW) - {1'b0, rate_arr[a]};
      end else begin
        mag_in[a] = {1'b0, rate_arr[a]};
      end
      dir_in[a] = ~rate_arr[a][RateW-1] & (rate_arr[a] != '0);
    end
  end

  always_comb begin
    if (play_idx_q == IdxW'(BufferDepth - 1)) begin
      play_idx_d = '0;
    end else begin
      play_idx_d = play_idx_q + IdxW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (tick_acc) begin
          state_d = StTickOut;
        end else if (refill_acc) begin
          state_d = StFill;
        end
      end
      StTickOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      StFill: begin
        if (fill_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  tdda_acc_unit u_acc_unit (
    .acc_i (acc_q[axis_q]),
    .mag_i (mag_q[axis_q]),
    .thr_i (thr_q),
    .res_o (res)
  );

  // A direction change suppresses the step of that entry and axis.
  assign step_bit = res.step & (dir_q[axis_q] == last_dir_q[axis_q]);
  assign wr_addr  = base_q + IdxW'(ent_cnt_q);

  always_comb begin
    entry_cur = (axis_q == '0) ? '0 : entry_q;
    entry_cur[EntryIdxW'(axis_q)] = step_bit;
    entry_cur[EntryIdxW'(axis_q) + EntryIdxW'(NumAxes)] = dir_q[axis_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThrReset;
      play_idx_q <= '0;
      half_due_q <= 1'b0;
      last_dir_q <= '0;
      mem_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      ent_cnt_q  <= '0;
      axis_q     <= '0;
      for (int a = 0; a < NumAxes; a++) begin
        acc_q[a] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (tick_acc) begin
        rd_vld_q   <= mem_vld_q[play_idx_q];
        play_idx_q <= play_idx_d;
        if (play_idx_d == '0 || play_idx_d == IdxW'(HalfDepth)) begin
          half_due_q <= 1'b1;
        end
      end
      if (refill_acc) begin
        half_due_q <= 1'b0;
        ent_cnt_q  <= '0;
        axis_q     <= '0;
      end
      if (state_q == StFill) begin
        acc_q[axis_q]      <= res.acc;
        last_dir_q[axis_q] <= dir_q[axis_q];
        if (fill_last_axis) begin
          mem_vld_q[wr_addr] <= 1'b1;
          ent_cnt_q          <= ent_cnt_q + HalfW'(1);
          axis_q             <= '0;
        end else begin
          axis_q <= axis_q + AxisW'(1);
        end
      end
    end
  end

  // Refill operands and the entry under construction.
  always_ff @(posedge clk_i) begin
    if (refill_acc) begin
      base_q <= (play_idx_q < IdxW'(HalfDepth)) ? IdxW'(HalfDepth) : '0;
      dir_q  <= dir_in;
      for (int a = 0; a < NumAxes; a++) begin
        mag_q[a] <= mag_in[a];
      end
    end
    if (state_q == StFill) begin
      entry_q <= entry_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StFill) && fill_last_axis) begin
      mem[wr_addr] <= entry_cur;
    end
    if (tick_acc) begin
      rd_data_q <= mem[play_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_entry_q <= rd_vld_q ? rd_data_q : '0;
      out_due_q   <= half_due_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign step_x_o     = out_entry_q[0];
  assign step_y_o     = out_entry_q[1];
  assign step_z_o     = out_entry_q[2];
  assign dir_x_o      = out_entry_q[NumAxes];
  assign dir_y_o      = out_entry_q[NumAxes+1];
  assign dir_z_o      = out_entry_q[NumAxes+2];
  assign refill_due_o = out_due_q;

endmodule

>>> design/tdda_checker.sv
// Port-level checks for the three-axis DDA step generator and the bind that attaches them.
module tdda_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic action_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic step_x_o,
  input logic step_y_o,
  input logic step_z_o,
  input logic dir_x_o,
  input logic dir_y_o,
  input logic dir_z_o,
  input logic refill_due_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_x_o) && $stable(step_y_o)
      && $stable(step_z_o) && $stable(dir_x_o) && $stable(dir_y_o) && $stable(dir_z_o)
      && $stable(refill_due_o))
    else $error("stalled result changed");

  // A tick request keeps the block busy for the following cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !action_i |=> in_stall_o)
    else $error("tick request not followed by busy cycle");

  // With the output register empty, a tick request yields a registered result.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !action_i && !out_valid_o |=> ##1 out_valid_o)
    else $error("tick request produced no result");

  // A refill request never produces a result.
  a_refill_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i && !out_valid_o |=> !out_valid_o)
    else $error("refill request produced a result");

endmodule

bind three_axis_dda_step_generator tdda_checker u_tdda_checker (.*);
